// ----- design/i2cseq_pkg.sv -----
// Package for the I2C master transaction sequencer.
// Holds the item codes, the payload structs and the default buffer depth.
// Depends on nothing; the top-level sequencer uses it, while the two interfaces do not.
package i2cseq_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 32;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_EVENT   = 2'd2;

  localparam logic [1:0] TXN_READ    = 2'd0;
  localparam logic [1:0] TXN_WRITE   = 2'd1;
  localparam logic [1:0] TXN_REGREAD = 2'd2;

  localparam logic [3:0] EV_START      = 4'd0;
  localparam logic [3:0] EV_RESTART    = 4'd1;
  localparam logic [3:0] EV_AW_ACK     = 4'd2;
  localparam logic [3:0] EV_AW_NAK     = 4'd3;
  localparam logic [3:0] EV_DW_ACK     = 4'd4;
  localparam logic [3:0] EV_DW_NAK     = 4'd5;
  localparam logic [3:0] EV_AR_ACK     = 4'd6;
  localparam logic [3:0] EV_AR_NAK     = 4'd7;
  localparam logic [3:0] EV_DR_ACK     = 4'd8;
  localparam logic [3:0] EV_DR_NAK     = 4'd9;

  localparam logic [1:0] ACK_LEAVE = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  localparam logic [2:0] RES_OK       = 3'd0;
  localparam logic [2:0] RES_BUSY     = 3'd1;
  localparam logic [2:0] RES_SIZE     = 3'd2;
  localparam logic [2:0] RES_ADDR_NAK = 3'd3;
  localparam logic [2:0] RES_DATA_NAK = 3'd4;
  localparam logic [2:0] RES_UNKNOWN  = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] txn_mode;
    logic [6:0] target_address;
    logic [5:0] byte_count;
    logic [7:0] register_index;
    logic [4:0] write_index;
    logic [7:0] write_byte;
    logic [3:0] event_code;
    logic [7:0] received_byte;
  } req_t;

  typedef struct packed {
    logic       issue_start;
    logic       issue_stop;
    logic [1:0] ack_control;
    logic       clear_interrupt;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [4:0] read_index;
    logic       done_res;
    logic [2:0] result_code;
  } cmd_t;

endpackage

// ----- design/i2cseq_req_if.sv -----
// Channel for request items: buffer loads, transaction requests and status events.
// Depends on nothing but the handshake of valid and ready.
interface i2cseq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] txn_mode;
  logic [6:0] target_address;
  logic [5:0] byte_count;
  logic [7:0] register_index;
  logic [4:0] write_index;
  logic [7:0] write_byte;
  logic [3:0] event_code;
  logic [7:0] received_byte;

  modport source (
    output valid, kind, txn_mode, target_address, byte_count, register_index,
           write_index, write_byte, event_code, received_byte,
    input  ready
  );

  modport sink (
    input  valid, kind, txn_mode, target_address, byte_count, register_index,
           write_index, write_byte, event_code, received_byte,
    output ready
  );
endinterface

// ----- design/i2cseq_cmd_if.sv -----
// Channel for command items sent to the byte-level controller and the caller.
// Depends on nothing but the handshake of valid and ready.
interface i2cseq_cmd_if;
  logic       valid;
  logic       ready;
  logic       issue_start;
  logic       issue_stop;
  logic [1:0] ack_control;
  logic       clear_interrupt;
  logic       send_valid;
  logic [7:0] send_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [4:0] read_index;
  logic       done_res;
  logic [2:0] result_code;

  modport source (
    output valid, issue_start, issue_stop, ack_control, clear_interrupt, send_valid,
           send_byte, read_valid, read_byte, read_index, done_res, result_code,
    input  ready
  );

  modport sink (
    input  valid, issue_start, issue_stop, ack_control, clear_interrupt, send_valid,
           send_byte, read_valid, read_byte, read_index, done_res, result_code,
    output ready
  );
endinterface

// ----- design/i2c_master_transaction_sequencer.sv -----
// Top level of the I2C master transaction sequencer.
// Uses i2cseq_pkg, i2cseq_req_if and i2cseq_cmd_if.
//
//   channel   modport  items
//   request   sink     buffer loads, transaction requests, status events
//   command   source   controller commands, received bytes, result codes
//
// A request item is taken into an input register, handled against the sequencer state and
// the write buffer, and its command lands in a result register, so one item per cycle is
// sustained while the command side takes the result register's items.
// Loads and unused kinds produce no command item and never wait on the command side.
// While the result register is full and not taken, the input register holds one item.
// Reset clears the sequencer state; the write buffer is undefined until written.
module i2c_master_transaction_sequencer #(
  parameter int unsigned BUFFER_DEPTH = i2cseq_pkg::BUFFER_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  i2cseq_req_if.sink         request,
  i2cseq_cmd_if.source       command
);

  localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW    = 9;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_READ,
    MODE_WRITE,
    MODE_REGREAD
  } mode_t;

  mode_t              active_mode;
  mode_t              mode_next;
  logic [7:0]         address_byte;
  logic [7:0]         addr_next;
  logic [PTR_W-1:0]   buffer_pointer;
  logic [PTR_W-1:0]   ptr_next;
  logic [5:0]         remaining_count;
  logic [5:0]         rem_next;
  logic [7:0]         data_buffer [BUFFER_DEPTH];

  i2cseq_pkg::req_t   req;
  logic               req_valid;
  i2cseq_pkg::cmd_t   res;
  i2cseq_pkg::cmd_t   res_next;
  logic               res_valid;

  logic               produces;
  logic               adv;
  logic               buf_we;
  logic [IDX_W-1:0]   buf_waddr;
  logic [7:0]         buf_wdata;
  logic               rd_ok;
  logic [IDX_W-1:0]   ptr_idx;
  logic [7:0]         rd_data;
  logic [PTR_W-1:0]   ptr_inc;
  logic [5:0]         rem_dec;
  logic               do_finish;
  logic [2:0]         fin_code;

  assign ptr_idx = IDX_W'(buffer_pointer);
  assign rd_ok   = CW'(buffer_pointer) < CW'(BUFFER_DEPTH);
  assign rd_data = rd_ok ? data_buffer[ptr_idx] : 8'd0;
  assign ptr_inc = rd_ok ? PTR_W'(buffer_pointer + 1'b1) : buffer_pointer;
  assign rem_dec = (remaining_count != 6'd0) ? remaining_count - 6'd1 : 6'd0;

  always_comb begin
    mode_next = active_mode;
    addr_next = address_byte;
    ptr_next  = buffer_pointer;
    rem_next  = remaining_count;
    res_next  = '0;
    buf_we    = 1'b0;
    buf_waddr = IDX_W'(req.write_index);
    buf_wdata = req.write_byte;
    produces  = 1'b0;
    do_finish = 1'b0;
    fin_code  = i2cseq_pkg::RES_OK;
    case (req.kind)
      i2cseq_pkg::KIND_LOAD: begin
        if (active_mode == MODE_IDLE && CW'(req.write_index) < CW'(BUFFER_DEPTH)) begin
          buf_we = 1'b1;
        end
      end
      i2cseq_pkg::KIND_REQUEST: begin
        produces = 1'b1;
        if (active_mode != MODE_IDLE) begin
          res_next.done_res    = 1'b1;
          res_next.result_code = i2cseq_pkg::RES_BUSY;
        end else if (req.byte_count == 6'd0 ||
                     CW'(req.byte_count) > CW'(BUFFER_DEPTH)) begin
          res_next.done_res    = 1'b1;
          res_next.result_code = i2cseq_pkg::RES_SIZE;
        end else begin
          addr_next = {req.target_address, 1'b0};
          ptr_next  = '0;
          rem_next  = req.byte_count;
          res_next.issue_start = 1'b1;
          case (req.txn_mode)
            i2cseq_pkg::TXN_READ: begin
              mode_next = MODE_READ;
              addr_next = {req.target_address, 1'b1};
            end
            i2cseq_pkg::TXN_WRITE: begin
              mode_next = MODE_WRITE;
            end
            i2cseq_pkg::TXN_REGREAD: begin
              mode_next = MODE_REGREAD;
              buf_we    = 1'b1;
              buf_waddr = '0;
              buf_wdata = req.register_index;
            end
            default: begin
              addr_next = address_byte;
              ptr_next  = buffer_pointer;
              rem_next  = remaining_count;
              res_next.issue_start = 1'b0;
              res_next.done_res    = 1'b1;
              res_next.result_code = i2cseq_pkg::RES_UNKNOWN;
            end
          endcase
        end
      end
      i2cseq_pkg::KIND_EVENT: begin
        produces = 1'b1;
        res_next.clear_interrupt = 1'b1;
        if (active_mode != MODE_IDLE) begin
          case (req.event_code)
            i2cseq_pkg::EV_START: begin
              res_next.send_valid = 1'b1;
              res_next.send_byte  = address_byte;
            end
            i2cseq_pkg::EV_RESTART: begin
              if (active_mode == MODE_REGREAD) begin
                res_next.send_valid = 1'b1;
                res_next.send_byte  = address_byte | 8'h01;
              end
            end
            i2cseq_pkg::EV_AW_ACK: begin
              res_next.send_valid = 1'b1;
              res_next.send_byte  = rd_data;
              if (active_mode == MODE_WRITE) begin
                ptr_next = ptr_inc;
                rem_next = rem_dec;
              end
            end
            i2cseq_pkg::EV_DW_ACK: begin
              if (active_mode == MODE_REGREAD) begin
                res_next.issue_start = 1'b1;
              end else if (remaining_count != 6'd0) begin
                rem_next = rem_dec;
                res_next.send_valid = 1'b1;
                res_next.send_byte  = rd_data;
                ptr_next = ptr_inc;
              end else begin
                do_finish = 1'b1;
              end
            end
            i2cseq_pkg::EV_AW_NAK, i2cseq_pkg::EV_AR_NAK: begin
              do_finish = 1'b1;
              fin_code  = i2cseq_pkg::RES_ADDR_NAK;
            end
            i2cseq_pkg::EV_DW_NAK: begin
              do_finish = 1'b1;
              fin_code  = i2cseq_pkg::RES_DATA_NAK;
            end
            i2cseq_pkg::EV_AR_ACK: begin
              res_next.ack_control = (remaining_count > 6'd1) ? i2cseq_pkg::ACK_SET
                                                               : i2cseq_pkg::ACK_CLEAR;
            end
            i2cseq_pkg::EV_DR_ACK, i2cseq_pkg::EV_DR_NAK: begin
              res_next.read_valid = 1'b1;
              res_next.read_byte  = req.received_byte;
              res_next.read_index = 5'(buffer_pointer);
              buf_we    = rd_ok;
              buf_waddr = ptr_idx;
              buf_wdata = req.received_byte;
              ptr_next  = ptr_inc;
              rem_next  = rem_dec;
              if (req.event_code == i2cseq_pkg::EV_DR_NAK) begin
                do_finish = 1'b1;
                fin_code  = (rem_dec == 6'd0) ? i2cseq_pkg::RES_OK
                                              : i2cseq_pkg::RES_DATA_NAK;
              end else if (rem_dec == 6'd0) begin
                do_finish = 1'b1;
              end else if (rem_dec == 6'd1) begin
                res_next.ack_control = i2cseq_pkg::ACK_CLEAR;
              end
            end
            default: begin
              do_finish = 1'b1;
              fin_code  = i2cseq_pkg::RES_UNKNOWN;
            end
          endcase
        end
        if (do_finish) begin
          res_next.issue_stop  = 1'b1;
          res_next.ack_control = i2cseq_pkg::ACK_SET;
          res_next.done_res    = 1'b1;
          res_next.result_code = fin_code;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign adv           = req_valid && (!produces || !res_valid || command.ready);
  assign request.ready = !req_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid       <= 1'b0;
      res_valid       <= 1'b0;
      active_mode     <= MODE_IDLE;
      address_byte    <= 8'd0;
      buffer_pointer  <= '0;
      remaining_count <= 6'd0;
    end else begin
      if (request.ready) begin
        req_valid <= request.valid;
      end
      if (adv && produces) begin
        res_valid <= 1'b1;
      end else if (command.ready) begin
        res_valid <= 1'b0;
      end
      if (adv) begin
        active_mode     <= mode_next;
        address_byte    <= addr_next;
        buffer_pointer  <= ptr_next;
        remaining_count <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.ready) begin
      req.kind           <= request.kind;
      req.txn_mode       <= request.txn_mode;
      req.target_address <= request.target_address;
      req.byte_count     <= request.byte_count;
      req.register_index <= request.register_index;
      req.write_index    <= request.write_index;
      req.write_byte     <= request.write_byte;
      req.event_code     <= request.event_code;
      req.received_byte  <= request.received_byte;
    end
    if (adv && produces) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && buf_we) begin
      data_buffer[buf_waddr] <= buf_wdata;
    end
  end

  assign command.valid           = res_valid;
  assign command.issue_start     = res.issue_start;
  assign command.issue_stop      = res.issue_stop;
  assign command.ack_control     = res.ack_control;
  assign command.clear_interrupt = res.clear_interrupt;
  assign command.send_valid      = res.send_valid;
  assign command.send_byte       = res.send_byte;
  assign command.read_valid      = res.read_valid;
  assign command.read_byte       = res.read_byte;
  assign command.read_index      = res.read_index;
  assign command.done_res        = res.done_res;
  assign command.result_code     = res.result_code;

  a_done_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && produces && res_next.done_res && res_next.result_code != i2cseq_pkg::RES_BUSY)
    |=> (active_mode == MODE_IDLE))
    else $error("finished or refused request did not leave the sequencer idle");

  a_start_enters_active: assert property (@(posedge clk) disable iff (rst)
    (adv && req.kind == i2cseq_pkg::KIND_REQUEST && res_next.issue_start)
    |=> (active_mode != MODE_IDLE))
    else $error("accepted request did not start a transaction");

  a_read_only_active: assert property (@(posedge clk) disable iff (rst)
    (adv && res_next.read_valid) |-> (active_mode != MODE_IDLE))
    else $error("received byte delivered while idle");

  a_pointer_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(buffer_pointer) <= CW'(BUFFER_DEPTH))
    else $error("buffer pointer beyond buffer depth");

endmodule
